>>> rtl/rlag_pkg.sv
// Package for the RMS level activity gate: shared constants, register indexes
// and the command and status structs between controller and datapath.
// No dependencies.
package rlag_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_OPEN   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLOSE  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD   = 3'd3;

    // Level format: 1/16 dBFS, 12 bit signed, floored at -120 dB.
    localparam int LEVEL_BITS  = 12;
    localparam int LEVEL_FLOOR = 1920;
    localparam logic signed [LEVEL_BITS-1:0] FLOOR_LEVEL  = -12'sd1920;
    localparam logic signed [LEVEL_BITS-1:0] OPEN_RESET   = -12'sd640;
    localparam logic signed [LEVEL_BITS-1:0] CLOSE_RESET  = -12'sd800;

    // Log arithmetic: Q16 log2 values and the dB scale 160*log10(2) in Q16.
    localparam int FRAC_BITS  = 16;
    localparam int DIFF_BITS  = 23;
    localparam int SCALE_BITS = 22;
    localparam logic [SCALE_BITS-1:0] DB_SCALE = 22'd3156528;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       take;
        logic       accum;
        logic       load_x;
        logic       src_n;
        logic       norm;
        logic       sq_mul;
        logic       sq_upd;
        logic [3:0] bit_idx;
        logic       lg_store;
        logic       diff;
        logic       prod;
        logic       level;
        logic       floor;
        logic       gate;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic zero;
        logic muted;
        logic x_top;
    } dp_stat_t;

endpackage

>>> rtl/rlag_in_if.sv
// Input stream interface of the RMS level activity gate.
// Carries one sample transaction; no package dependency.
interface rlag_in_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_of_block;
    logic [31:0]                   now_ms;
    logic                          muted;

    modport source (output valid, sample, last_of_block, now_ms, muted, input ready);
    modport sink   (input valid, sample, last_of_block, now_ms, muted, output ready);
endinterface

>>> rtl/rlag_out_if.sv
// Output stream interface of the RMS level activity gate.
// Carries one block result transaction; no package dependency.
interface rlag_out_if ();
    logic              valid;
    logic              ready;
    logic              active;
    logic              changed;
    logic signed [11:0] level;

    modport source (output valid, active, changed, level, input ready);
    modport sink   (input valid, active, changed, level, output ready);
endinterface

>>> rtl/rlag_datapath.sv
// Datapath of the RMS level activity gate: square accumulation, the shared
// iterative log2 unit, dB scaling, gate state and the result register.
// Depends on rlag_pkg.
module rlag_datapath
    import rlag_pkg::*;
#(
    parameter int BLOCK_MAX   = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dp_cmd_t                       cmd,
    output dp_stat_t                      stat,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last_of_block,
    input  logic [31:0]                   now_ms,
    input  logic                          muted,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    output logic                          active,
    output logic                          changed,
    output logic signed [LEVEL_BITS-1:0]  level
);

    localparam int SUMW   = 2 * SAMPLE_BITS - 1 + $clog2(BLOCK_MAX);
    localparam int CNTW   = $clog2(BLOCK_MAX + 1);
    localparam int NW     = (SUMW > 32) ? SUMW : 32;
    localparam int EW     = $clog2(NW);
    localparam int SQW    = 2 * SAMPLE_BITS;
    localparam int PRODW  = DIFF_BITS + SCALE_BITS + 1;
    localparam logic [DIFF_BITS-1:0] LN_OFS = DIFF_BITS'((2 * SAMPLE_BITS - 2) * 65536);
    localparam logic [PRODW-1:0] ROUND_HALF = PRODW'(64'd1 << 31);

    // Clamp a threshold into the level range.
    function automatic logic signed [LEVEL_BITS-1:0] clamp_thr(
        input logic signed [LEVEL_BITS-1:0] t
    );
        logic signed [LEVEL_BITS-1:0] r;
        r = t;
        if (t < FLOOR_LEVEL) r = FLOOR_LEVEL;
        else if (t > 12'sd0) r = 12'sd0;
        return r;
    endfunction

    // Latched input transaction.
    logic [SAMPLE_BITS-1:0]  mag_reg;
    logic                    last_reg;
    logic                    muted_reg;
    logic [TIME_BITS-1:0]    now_reg;

    // Block accumulators and their snapshot at the block end.
    logic [SUMW-1:0] sum_reg;
    logic [CNTW-1:0] tally_reg;
    logic [SUMW-1:0] work_s_reg;
    logic [CNTW-1:0] work_n_reg;

    // Log unit registers.
    logic [NW-1:0]        x_reg;
    logic [EW-1:0]        e_reg;
    logic [31:0]          m_reg;
    logic [15:0]          f_reg;
    logic [63:0]          p_reg;
    logic [DIFF_BITS-1:0] ls_reg;
    logic [DIFF_BITS-1:0] ln_reg;
    logic [DIFF_BITS-1:0] d_reg;
    logic [PRODW-1:0]     lp_reg;
    logic signed [LEVEL_BITS-1:0] level_reg;

    // Gate state and configuration.
    logic                 gate_open_reg, gate_open_next;
    logic                 rise_valid_reg, rise_valid_next;
    logic [TIME_BITS-1:0] rise_time_reg, rise_time_next;
    logic                 loud_valid_reg, loud_valid_next;
    logic [TIME_BITS-1:0] loud_time_reg, loud_time_next;
    logic signed [LEVEL_BITS-1:0] open_thr_reg;
    logic signed [LEVEL_BITS-1:0] close_thr_reg;
    logic [15:0]          attack_reg;
    logic [15:0]          hold_reg;

    // Result register.
    logic                 active_reg;
    logic                 changed_reg;
    logic signed [LEVEL_BITS-1:0] out_level_reg;

    // Input conversion: magnitude of the sample and the time cut to TIME_BITS.
    logic [SAMPLE_BITS-1:0] in_mag;
    logic [63:0]            now_wide;
    assign in_mag   = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
    assign now_wide = {32'd0, now_ms};

    // Square and accumulate, ignoring samples past the block limit.
    logic [SQW-1:0]  sq;
    logic            room;
    logic [SUMW-1:0] acc_sum;
    logic [CNTW-1:0] acc_tally;
    assign sq        = SQW'(mag_reg) * SQW'(mag_reg);
    assign room      = tally_reg < CNTW'(BLOCK_MAX);
    assign acc_sum   = room ? sum_reg + SUMW'(sq) : sum_reg;
    assign acc_tally = room ? tally_reg + CNTW'(1) : tally_reg;

    // One squaring step of the log fraction.
    logic [32:0]          m_sq;
    logic [DIFF_BITS-1:0] lg_val;
    assign m_sq   = p_reg[63:31];
    assign lg_val = DIFF_BITS'({e_reg, f_reg});

    // Rounded, saturated dB magnitude.
    logic [PRODW-1:0] rounded;
    logic [PRODW-33:0] db_mag;
    logic [LEVEL_BITS-1:0] db_sat;
    assign rounded = lp_reg + ROUND_HALF;
    assign db_mag  = rounded[PRODW-1:32];
    assign db_sat  = (db_mag > (PRODW-32)'(LEVEL_FLOOR)) ? LEVEL_BITS'(LEVEL_FLOOR)
                                                          : LEVEL_BITS'(db_mag);

    // Gate decision for the finished block.
    logic signed [LEVEL_BITS-1:0] open_eff;
    logic signed [LEVEL_BITS-1:0] close_c;
    logic signed [LEVEL_BITS-1:0] close_eff;
    logic [TIME_BITS-1:0]         rise_base;
    logic                         attack_ok;
    logic                         hold_ok;
    logic signed [LEVEL_BITS-1:0] blk_level;

    assign open_eff  = clamp_thr(open_thr_reg);
    assign close_c   = clamp_thr(close_thr_reg);
    assign close_eff = (close_c > open_eff) ? open_eff : close_c;
    assign rise_base = rise_valid_reg ? rise_time_reg : now_reg;
    assign attack_ok = TIME_BITS'(now_reg - rise_base) >= TIME_BITS'(attack_reg);
    assign hold_ok   = TIME_BITS'(now_reg - loud_time_reg) >= TIME_BITS'(hold_reg);
    assign blk_level = muted_reg ? FLOOR_LEVEL : level_reg;

    always_comb
    begin
        gate_open_next  = gate_open_reg;
        rise_valid_next = rise_valid_reg;
        rise_time_next  = rise_time_reg;
        loud_valid_next = loud_valid_reg;
        loud_time_next  = loud_time_reg;
        if (muted_reg)
        begin
            gate_open_next  = 1'b0;
            rise_valid_next = 1'b0;
            rise_time_next  = '0;
            loud_valid_next = 1'b0;
            loud_time_next  = '0;
        end
        else if (!gate_open_reg)
        begin
            if (level_reg < open_eff)
            begin
                rise_valid_next = 1'b0;
            end
            else
            begin
                if (!rise_valid_reg)
                begin
                    rise_valid_next = 1'b1;
                    rise_time_next  = now_reg;
                end
                if (attack_ok)
                begin
                    gate_open_next  = 1'b1;
                    loud_valid_next = 1'b1;
                    loud_time_next  = now_reg;
                end
            end
        end
        else if (level_reg >= close_eff)
        begin
            loud_valid_next = 1'b1;
            loud_time_next  = now_reg;
        end
        else if (!loud_valid_reg || hold_ok)
        begin
            gate_open_next  = 1'b0;
            rise_valid_next = 1'b0;
            rise_time_next  = '0;
            loud_valid_next = 1'b0;
            loud_time_next  = '0;
        end
    end

    // Input latch and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 1'b0;
            muted_reg <= 1'b0;
            sum_reg   <= '0;
            tally_reg <= '0;
        end
        else
        begin
            if (cmd.take)
            begin
                last_reg  <= last_of_block;
                muted_reg <= muted;
            end
            if (cmd.accum)
            begin
                if (last_reg)
                begin
                    sum_reg   <= '0;
                    tally_reg <= '0;
                end
                else
                begin
                    sum_reg   <= acc_sum;
                    tally_reg <= acc_tally;
                end
            end
        end
    end

    // Payload registers of the input latch and the level computation.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            mag_reg <= in_mag;
            now_reg <= now_wide[TIME_BITS-1:0];
        end
        if (cmd.accum && last_reg)
        begin
            work_s_reg <= acc_sum;
            work_n_reg <= acc_tally;
        end
        if (cmd.load_x)
        begin
            x_reg <= cmd.src_n ? NW'(work_n_reg) : NW'(work_s_reg);
            e_reg <= EW'(NW - 1);
        end
        if (cmd.norm)
        begin
            if (x_reg[NW-1])
            begin
                m_reg <= x_reg[NW-1 -: 32];
                f_reg <= '0;
            end
            else
            begin
                x_reg <= x_reg << 1;
                e_reg <= e_reg - EW'(1);
            end
        end
        if (cmd.sq_mul)
        begin
            p_reg <= 64'(m_reg) * 64'(m_reg);
        end
        if (cmd.sq_upd)
        begin
            if (m_sq[32])
            begin
                f_reg[cmd.bit_idx] <= 1'b1;
                m_reg <= m_sq[32:1];
            end
            else
            begin
                m_reg <= m_sq[31:0];
            end
        end
        if (cmd.lg_store)
        begin
            if (cmd.src_n) ln_reg <= lg_val + LN_OFS;
            else           ls_reg <= lg_val;
        end
        if (cmd.diff)
        begin
            d_reg <= (ln_reg > ls_reg) ? ln_reg - ls_reg : '0;
        end
        if (cmd.prod)
        begin
            lp_reg <= PRODW'(d_reg) * PRODW'(DB_SCALE);
        end
        if (cmd.level)
        begin
            level_reg <= -$signed(db_sat);
        end
        if (cmd.floor)
        begin
            level_reg <= FLOOR_LEVEL;
        end
        if (cmd.gate)
        begin
            out_level_reg <= blk_level;
        end
    end

    // Gate state, configuration registers and result flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_open_reg  <= 1'b0;
            rise_valid_reg <= 1'b0;
            rise_time_reg  <= '0;
            loud_valid_reg <= 1'b0;
            loud_time_reg  <= '0;
            open_thr_reg   <= OPEN_RESET;
            close_thr_reg  <= CLOSE_RESET;
            attack_reg     <= '0;
            hold_reg       <= '0;
            active_reg     <= 1'b0;
            changed_reg    <= 1'b0;
        end
        else if (cfg_we && cfg_index <= REG_HOLD)
        begin
            // Any valid register write also closes the gate.
            unique case (cfg_index)
                REG_OPEN:   open_thr_reg  <= cfg_data[LEVEL_BITS-1:0];
                REG_CLOSE:  close_thr_reg <= cfg_data[LEVEL_BITS-1:0];
                REG_ATTACK: attack_reg    <= cfg_data;
                REG_HOLD:   hold_reg      <= cfg_data;
                default:    ;
            endcase
            gate_open_reg  <= 1'b0;
            rise_valid_reg <= 1'b0;
            rise_time_reg  <= '0;
            loud_valid_reg <= 1'b0;
            loud_time_reg  <= '0;
        end
        else if (cmd.gate)
        begin
            gate_open_reg  <= gate_open_next;
            rise_valid_reg <= rise_valid_next;
            rise_time_reg  <= rise_time_next;
            loud_valid_reg <= loud_valid_next;
            loud_time_reg  <= loud_time_next;
            active_reg     <= gate_open_next;
            changed_reg    <= gate_open_next != gate_open_reg;
        end
    end

    // Status and result outputs.
    assign stat.last  = last_reg;
    assign stat.zero  = (work_s_reg == '0) || (work_n_reg == '0);
    assign stat.muted = muted_reg;
    assign stat.x_top = x_reg[NW-1];

    assign active  = active_reg;
    assign changed = changed_reg;
    assign level   = out_level_reg;

endmodule

>>> rtl/rlag_controller.sv
// Controller of the RMS level activity gate: sequences accumulation, the two
// log2 passes, scaling and the gate update, and owns both handshakes.
// Depends on rlag_pkg.
module rlag_controller
    import rlag_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ACC   = 4'd1;
    localparam logic [3:0] ST_CHECK = 4'd2;
    localparam logic [3:0] ST_LOAD  = 4'd3;
    localparam logic [3:0] ST_NORM  = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_UPD   = 4'd6;
    localparam logic [3:0] ST_STORE = 4'd7;
    localparam logic [3:0] ST_DIFF  = 4'd8;
    localparam logic [3:0] ST_PROD  = 4'd9;
    localparam logic [3:0] ST_LEVEL = 4'd10;
    localparam logic [3:0] ST_GATE  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       pass_reg, pass_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.src_n      = pass_reg;
        cmd.bit_idx    = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = stat.last ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK:
            begin
                if (stat.muted || stat.zero)
                begin
                    cmd.floor  = 1'b1;
                    state_next = ST_GATE;
                end
                else
                begin
                    pass_next  = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load_x = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                cmd.norm = 1'b1;
                if (stat.x_top)
                begin
                    cnt_next   = 4'd15;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.sq_mul = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.sq_upd = 1'b1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    cnt_next   = cnt_reg - 4'd1;
                    state_next = ST_MUL;
                end
            end
            ST_STORE:
            begin
                cmd.lg_store = 1'b1;
                if (pass_reg)
                begin
                    state_next = ST_DIFF;
                end
                else
                begin
                    pass_next  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                cmd.level  = 1'b1;
                state_next = ST_GATE;
            end
            ST_GATE:
            begin
                // Wait for the result register to free up.
                if (slot_free)
                begin
                    cmd.gate       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pass_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/rms_level_activity_gate.sv
// Top level of the RMS level activity gate: joins controller and datapath
// to the stream interfaces and the configuration write port.
// Depends on rlag_pkg, rlag_in_if, rlag_out_if, rlag_controller, rlag_datapath.
//
//  Channel   Kind          Payload
//  in_ch     stream sink   sample, last_of_block, now_ms, muted
//  out_ch    stream source active, changed, level (one per block)
//  cfg_*     write port    cfg_index selects register, cfg_data value
//
// A sample that does not end a block is accepted, then squared and added.
// A block-end sample then runs two log2 passes, on the sum and on the tally.
// Each pass normalizes by a shift count of up to 42, then takes the shared log
// unit's 16 multiply-and-square steps; difference, scaling, level, gate follow.
// A muted or silent block skips the log passes and goes to the gate update.
// A finished result waits in the output register; further samples are taken
// meanwhile, but the next block end waits for that register to be taken.
// Reset clears the accumulators, gate state and configuration at once.
module rms_level_activity_gate
    import rlag_pkg::*;
#(
    parameter int BLOCK_MAX   = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    rlag_in_if.sink                  in_ch,
    rlag_out_if.source               out_ch,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencing and handshakes.
    rlag_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic, gate state and result register.
    rlag_datapath #(
        .BLOCK_MAX   (BLOCK_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .sample        (in_ch.sample),
        .last_of_block (in_ch.last_of_block),
        .now_ms        (in_ch.now_ms),
        .muted         (in_ch.muted),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .active        (out_ch.active),
        .changed       (out_ch.changed),
        .level         (out_ch.level)
    );

endmodule
